### design/vbfe_pkg.sv
// Shared types, constants and helpers of the voxel boundary face extractor.
package vbfe_pkg;

	// Largest volume the block is built for.
	localparam int MAX_X = 256;
	localparam int MAX_Y = 256;
	localparam int MAX_Z = 256;

	// Coordinates never pass 256 per axis.
	localparam int CAP_X = (MAX_X > 256) ? 256 : MAX_X;
	localparam int CAP_Y = (MAX_Y > 256) ? 256 : MAX_Y;
	localparam int CAP_Z = (MAX_Z > 256) ? 256 : MAX_Z;

	localparam int XW = $clog2(CAP_X);
	localparam int YW = $clog2(CAP_Y);
	localparam int ZW = $clog2(CAP_Z);

	localparam int VALUE_W = 16;
	localparam int SIZE_W  = 9;
	localparam int COORD_W = 8;
	localparam int CODE_W  = 4;
	localparam int INDEX_W = 2;
	localparam int SLOTS   = 6;

	// Plane of inside flags, one per (x, y) column.
	localparam int ADDR_W      = XW + YW;
	localparam int PLANE_DEPTH = 1 << ADDR_W;

	typedef logic [ADDR_W-1:0] addr_t;

	typedef enum logic [INDEX_W-1:0] {
		REG_THRESHOLD,
		REG_SIZE_X,
		REG_SIZE_Y,
		REG_SIZE_Z
	} reg_index_t;

	typedef enum logic [CODE_W-1:0] {
		FACE_OUT_LX,
		FACE_OUT_LY,
		FACE_OUT_LZ,
		FACE_IN_LX,
		FACE_IN_LY,
		FACE_IN_LZ,
		FACE_HI_X,
		FACE_HI_Y,
		FACE_HI_Z
	} face_code_t;

	// Access of the plane memory for one accepted item.
	typedef struct packed {
		logic  en;
		logic  wr_data;
		addr_t addr;
		addr_t addr_up;
	} plane_req_t;

	// Clamp a written size into 1..cap.
	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s,
	                                               input logic [SIZE_W-1:0] cap);
		logic [SIZE_W-1:0] r;
		if (s == '0) begin
			r = SIZE_W'(1);
		end else if (s > cap) begin
			r = cap;
		end else begin
			r = s;
		end
		return r;
	endfunction

	// Slots 0..2 are the low x/y/z faces, slots 3..5 the high closing faces.
	function automatic face_code_t face_code(input logic is_in, input logic [2:0] slot);
		face_code_t c;
		unique case (slot)
			3'd0:    c = is_in ? FACE_IN_LX : FACE_OUT_LX;
			3'd1:    c = is_in ? FACE_IN_LY : FACE_OUT_LY;
			3'd2:    c = is_in ? FACE_IN_LZ : FACE_OUT_LZ;
			3'd3:    c = FACE_HI_X;
			3'd4:    c = FACE_HI_Y;
			3'd5:    c = FACE_HI_Z;
			default: c = FACE_OUT_LX;
		endcase
		return c;
	endfunction

endpackage

### design/vbfe_plane_ram.sv
// Plane of inside flags: one write port and two registered read ports, read-first.
module vbfe_plane_ram import vbfe_pkg::*; (
	input  logic       clk,
	input  plane_req_t req,
	output logic       rd_data,
	output logic       rd_data_up
);

	logic mem [PLANE_DEPTH];

	// Read and write the same edge; the column read sees the older slice.
	always_ff @(posedge clk) begin
		if (req.en) begin
			rd_data       <= mem[req.addr];
			rd_data_up    <= mem[req.addr_up];
			mem[req.addr] <= req.wr_data;
		end
	end

endmodule

### design/voxel_boundary_face_extractor.sv
// Top level of the voxel boundary face extractor: position tracking, plane update, face emitter.
//
// Voxels enter in raster order (x fastest, then y, then z) and leave as boundary faces, one
// face per item on the output channel, each tagged with its voxel's coordinates and a face
// code; last_face marks the final face of a voxel. A voxel with no face or one face is done
// at once, so a sparse surface streams at one voxel per clock while the output is free. A voxel
// with n faces (at most six) holds the emitter until all are out, since the single output
// register takes one face per cycle. The inside flags of the last slice live in a 64K x 1 plane
// memory with two registered read ports; every accepted voxel reads its own column and the
// column one row up and writes its own flag in the same cycle, so no forwarding is needed.
// The plane is not cleared: after reset a volume must start at (0,0,0) with fixed sizes.
// Write threshold and sizes only while the block is idle; sizes are clamped to 1..256.
module voxel_boundary_face_extractor import vbfe_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,

	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [INDEX_W-1:0]        cfg_index,
	input  logic [VALUE_W-1:0]        cfg_data,

	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [VALUE_W-1:0] voxel_value,

	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [COORD_W-1:0]        face_x,
	output logic [COORD_W-1:0]        face_y,
	output logic [COORD_W-1:0]        face_z,
	output logic [CODE_W-1:0]         face_code,
	output logic                      last_face
);

	// Configuration registers; sizes are stored already clamped.
	logic signed [VALUE_W-1:0] threshold_q;
	logic [SIZE_W-1:0]         size_x_q, size_y_q, size_z_q;

	// Position of the next voxel and inside flag of the previous one.
	logic [XW-1:0] pos_x_q;
	logic [YW-1:0] pos_y_q;
	logic [ZW-1:0] pos_z_q;
	logic          prev_inside_q;

	// Emitter stage: one voxel waiting for its faces to go out.
	logic          valid_s1;
	logic [XW-1:0] x_s1;
	logic [YW-1:0] y_s1;
	logic [ZW-1:0] z_s1;
	logic          inside_s1;
	logic          lx_s1;
	logic          y_nz_s1;
	logic          z_nz_s1;
	logic [2:0]    hi_s1;
	logic [SLOTS-1:0] sent_s1;

	// Output register.
	logic               out_valid_q;
	logic [XW-1:0]      face_x_q;
	logic [YW-1:0]      face_y_q;
	logic [ZW-1:0]      face_z_q;
	face_code_t         face_code_q;
	logic               last_face_q;

	logic          accept;
	logic          cur_inside;
	logic [XW-1:0] cx;
	logic [YW-1:0] cy;
	logic [ZW-1:0] cz;
	logic [SIZE_W-1:0] cx_inc, cy_inc, cz_inc;
	logic          end_x, end_y, end_z;

	plane_req_t    plane_req;
	logic          col_flag, up_flag;

	logic [2:0]       low_hit;
	logic [SLOTS-1:0] mask, remain, pick_bit;
	logic [2:0]       pick;
	logic             out_take, emit, is_last, s1_done;

	// Configuration: always ready; each index selects one of the four registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= '0;
			size_x_q    <= SIZE_W'(CAP_X);
			size_y_q    <= SIZE_W'(CAP_Y);
			size_z_q    <= SIZE_W'(CAP_Z);
		end else if (cfg_valid) begin
			unique case (reg_index_t'(cfg_index))
				REG_THRESHOLD: threshold_q <= $signed(cfg_data);
				REG_SIZE_X:    size_x_q <= eff_size(cfg_data[SIZE_W-1:0], SIZE_W'(CAP_X));
				REG_SIZE_Y:    size_y_q <= eff_size(cfg_data[SIZE_W-1:0], SIZE_W'(CAP_Y));
				REG_SIZE_Z:    size_z_q <= eff_size(cfg_data[SIZE_W-1:0], SIZE_W'(CAP_Z));
			endcase
		end
	end

	// Current coordinates: drop any coordinate left beyond a lowered size.
	always_comb begin
		cx = (SIZE_W'(pos_x_q) >= size_x_q) ? '0 : pos_x_q;
		cy = (SIZE_W'(pos_y_q) >= size_y_q) ? '0 : pos_y_q;
		cz = (SIZE_W'(pos_z_q) >= size_z_q) ? '0 : pos_z_q;
		cx_inc = SIZE_W'(cx) + SIZE_W'(1);
		cy_inc = SIZE_W'(cy) + SIZE_W'(1);
		cz_inc = SIZE_W'(cz) + SIZE_W'(1);
		end_x  = (cx_inc == size_x_q);
		end_y  = (cy_inc == size_y_q);
		end_z  = (cz_inc == size_z_q);
	end

	assign cur_inside = (voxel_value <= threshold_q);
	assign accept     = in_valid && in_ready;

	// Plane access: read this column and the one a row up, write the new flag.
	always_comb begin
		plane_req.en      = accept;
		plane_req.wr_data = cur_inside;
		plane_req.addr    = {cy, cx};
		plane_req.addr_up = {cy - YW'(1), cx};
	end

	vbfe_plane_ram u_plane (
		.clk        (clk),
		.req        (plane_req),
		.rd_data    (col_flag),
		.rd_data_up (up_flag)
	);

	// Advance the raster position and take the new item into the emitter stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q       <= '0;
			pos_y_q       <= '0;
			pos_z_q       <= '0;
			prev_inside_q <= 1'b0;
		end else if (accept) begin
			prev_inside_q <= cur_inside;
			if (!end_x) begin
				pos_x_q <= cx + XW'(1);
				pos_y_q <= cy;
				pos_z_q <= cz;
			end else begin
				pos_x_q <= '0;
				if (!end_y) begin
					pos_y_q <= cy + YW'(1);
					pos_z_q <= cz;
				end else begin
					pos_y_q <= '0;
					pos_z_q <= end_z ? '0 : cz + ZW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1      <= cx;
			y_s1      <= cy;
			z_s1      <= cz;
			inside_s1 <= cur_inside;
			lx_s1     <= (cx != '0) && prev_inside_q;
			y_nz_s1   <= (cy != '0);
			z_nz_s1   <= (cz != '0);
			hi_s1     <= {end_z, end_y, end_x};
			sent_s1   <= '0;
		end else if (emit) begin
			sent_s1   <= sent_s1 | pick_bit;
		end
	end

	// Face mask: an outside voxel faces its inside lower neighbors, an inside voxel its
	// outside or absent lower neighbors plus the high edges it sits on.
	always_comb begin
		low_hit = {z_nz_s1 && col_flag, y_nz_s1 && up_flag, lx_s1};
		mask    = {inside_s1 ? hi_s1 : 3'b000, inside_s1 ? ~low_hit : low_hit};
		remain  = mask & ~sent_s1;
		pick_bit = remain & (~remain + SLOTS'(1));
		pick    = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (remain[i]) begin
				pick = 3'(i);
			end
		end
		out_take = !out_valid_q || out_ready;
		emit     = valid_s1 && (remain != '0) && out_take;
		is_last  = ((remain & ~pick_bit) == '0);
		// Free the stage once the last face is handed over, or at once if there is none.
		s1_done  = valid_s1 && ((remain == '0) || (emit && is_last));
	end

	assign in_ready = !valid_s1 || s1_done;

	// Output register: hold a face until taken, refill in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			face_x_q    <= x_s1;
			face_y_q    <= y_s1;
			face_z_q    <= z_s1;
			face_code_q <= vbfe_pkg::face_code(inside_s1, pick);
			last_face_q <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign face_x    = COORD_W'(face_x_q);
	assign face_y    = COORD_W'(face_y_q);
	assign face_z    = COORD_W'(face_z_q);
	assign face_code = CODE_W'(face_code_q);
	assign last_face = last_face_q;

endmodule
